/* src/stlc_pkg.sv */
// stlc_pkg: shared types, constants and the microcode program of the lunar date converter
// depends on nothing; used by stlc_seq, stlc_dp and solar_to_lunar_date_convert
`default_nettype none

package stlc_pkg;

  localparam int unsigned InW   = 64;
  localparam int unsigned OutW  = 24;
  localparam int unsigned StepW = 4;

  localparam logic [4:0] ShortMonth = 5'h1d;
  localparam logic [4:0] LongMonth  = 5'h1e;
  localparam logic [6:0] LastYear   = 7'h63;
  localparam logic [3:0] LastMonth  = 4'd12;
  localparam logic [3:0] LastSlot   = 4'd13;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_PREP,
    OP_FWD_INIT,
    OP_FWD_MONTH,
    OP_FWD_DAY,
    OP_BWD_INIT,
    OP_BWD_MONTH,
    OP_BWD_DAY,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_AFTER_FEST,
    COND_FWD_FIT,
    COND_BWD_FIT,
    COND_OUT_FREE
  } cond_e;

  typedef enum logic [1:0] {
    EXEC_ALWAYS,
    EXEC_TRUE,
    EXEC_FALSE
  } exec_e;

  localparam logic [StepW-1:0] StepIdle    = 4'd0;
  localparam logic [StepW-1:0] StepPrep    = 4'd1;
  localparam logic [StepW-1:0] StepSplit   = 4'd2;
  localparam logic [StepW-1:0] StepFwdInit = 4'd3;
  localparam logic [StepW-1:0] StepFwdWalk = 4'd4;
  localparam logic [StepW-1:0] StepFwdEnd  = 4'd5;
  localparam logic [StepW-1:0] StepBwdInit = 4'd6;
  localparam logic [StepW-1:0] StepBwdWalk = 4'd7;
  localparam logic [StepW-1:0] StepBwdEnd  = 4'd8;
  localparam logic [StepW-1:0] StepEmit    = 4'd9;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    exec_e            on;
    logic [StepW-1:0] jt;
    logic [StepW-1:0] jf;
  } ucode_t;

  typedef struct packed {
    op_e  op;
    logic exec;
  } ctrl_t;

  typedef struct packed {
    logic after_fest;
    logic fwd_fit;
    logic bwd_fit;
  } status_t;

  typedef struct packed {
    logic       wrap;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } res_t;

  // program store
  function automatic ucode_t ucode_rom(input logic [StepW-1:0] pc);
    ucode_t w;
    unique case (pc)
      StepIdle:    w = '{OP_LATCH,     COND_IN_VALID,   EXEC_TRUE,   StepPrep,    StepIdle};
      StepPrep:    w = '{OP_PREP,      COND_ALWAYS,     EXEC_ALWAYS, StepSplit,   StepSplit};
      StepSplit:   w = '{OP_NOP,       COND_AFTER_FEST, EXEC_ALWAYS, StepFwdInit, StepBwdInit};
      StepFwdInit: w = '{OP_FWD_INIT,  COND_ALWAYS,     EXEC_ALWAYS, StepFwdWalk, StepFwdWalk};
      StepFwdWalk: w = '{OP_FWD_MONTH, COND_FWD_FIT,    EXEC_FALSE,  StepFwdEnd,  StepFwdWalk};
      StepFwdEnd:  w = '{OP_FWD_DAY,   COND_ALWAYS,     EXEC_ALWAYS, StepEmit,    StepEmit};
      StepBwdInit: w = '{OP_BWD_INIT,  COND_ALWAYS,     EXEC_ALWAYS, StepBwdWalk, StepBwdWalk};
      StepBwdWalk: w = '{OP_BWD_MONTH, COND_BWD_FIT,    EXEC_FALSE,  StepBwdEnd,  StepBwdWalk};
      StepBwdEnd:  w = '{OP_BWD_DAY,   COND_ALWAYS,     EXEC_ALWAYS, StepEmit,    StepEmit};
      StepEmit:    w = '{OP_EMIT,      COND_OUT_FREE,   EXEC_TRUE,   StepIdle,    StepEmit};
      default:     w = '{OP_NOP,       COND_ALWAYS,     EXEC_ALWAYS, StepIdle,    StepIdle};
    endcase
    return w;
  endfunction

  // day-of-year offset of the first of each month, non-leap
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] v;
    unique case (idx)
      4'd0:    v = 9'h000;
      4'd1:    v = 9'h01f;
      4'd2:    v = 9'h03b;
      4'd3:    v = 9'h05a;
      4'd4:    v = 9'h078;
      4'd5:    v = 9'h097;
      4'd6:    v = 9'h0b5;
      4'd7:    v = 9'h0d4;
      4'd8:    v = 9'h0f3;
      4'd9:    v = 9'h111;
      4'd10:   v = 9'h130;
      4'd11:   v = 9'h14e;
      default: v = 9'h000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* src/stlc_seq.sv */
// stlc_seq: step counter and microcode store, evaluates jump conditions
// depends on stlc_pkg
`default_nettype none

module stlc_seq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             out_free_i,
  input  wire stlc_pkg::status_t status_i,
  output logic                  in_ready_o,
  output stlc_pkg::ctrl_t       ctrl_o
);

  logic [stlc_pkg::StepW-1:0] pc_q, pc_d;
  stlc_pkg::ucode_t           uw;
  logic                       cond_ok;

  assign uw = stlc_pkg::ucode_rom(pc_q);

  always_comb begin
    case (uw.cond)
      stlc_pkg::COND_ALWAYS:     cond_ok = 1'b1;
      stlc_pkg::COND_IN_VALID:   cond_ok = in_valid_i;
      stlc_pkg::COND_AFTER_FEST: cond_ok = status_i.after_fest;
      stlc_pkg::COND_FWD_FIT:    cond_ok = status_i.fwd_fit;
      stlc_pkg::COND_BWD_FIT:    cond_ok = status_i.bwd_fit;
      stlc_pkg::COND_OUT_FREE:   cond_ok = out_free_i;
      default:                   cond_ok = 1'b1;
    endcase
  end

  always_comb begin
    ctrl_o.op = uw.op;
    case (uw.on)
      stlc_pkg::EXEC_TRUE:  ctrl_o.exec = cond_ok;
      stlc_pkg::EXEC_FALSE: ctrl_o.exec = !cond_ok;
      default:              ctrl_o.exec = 1'b1;
    endcase
    pc_d = cond_ok ? uw.jt : uw.jf;
  end

  assign in_ready_o = (pc_q == stlc_pkg::StepIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= stlc_pkg::StepIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

/* src/stlc_dp.sv */
// stlc_dp: datapath of the converter, day-of-year count and lunar month walk
// depends on stlc_pkg; driven by stlc_seq
`default_nettype none

module stlc_dp (
  input  wire logic                     clk_i,
  input  wire stlc_pkg::ctrl_t          ctrl_i,
  input  wire logic [stlc_pkg::InW-1:0] in_data_i,
  output stlc_pkg::status_t             status_o,
  output stlc_pkg::res_t                res_o
);

  logic [6:0]  year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;
  logic [23:0] cur_q;
  logic [16:0] prev_q;
  logic [8:0]  doy_q;
  logic [5:0]  fest_q;
  logic [3:0]  lmon_q;
  logic [3:0]  slot_q;
  logic        second_q;
  logic [3:0]  leap_q;
  logic [12:0] sizes_q;
  logic [4:0]  lday_q;
  logic        wrap_q;

  logic [6:0]  in_year;
  logic [3:0]  in_month;
  logic [4:0]  in_day;
  logic [3:0]  mon_c;
  logic [4:0]  day_c;
  logic [8:0]  doy_calc;
  logic [5:0]  fest_calc;
  logic [3:0]  size_idx;
  logic        slot_ok;
  logic [4:0]  len;
  logic        fwd_second;
  logic [3:0]  fwd_lmon;
  logic [3:0]  bwd_lmon;
  logic        bwd_second;

  assign in_year  = in_data_i[6:0];
  assign in_month = in_data_i[10:7];
  assign in_day   = in_data_i[15:11];

  assign mon_c = (in_month == 4'd0) ? 4'd1 :
                 (in_month > stlc_pkg::LastMonth) ? stlc_pkg::LastMonth : in_month;
  assign day_c = (in_day == 5'd0) ? 5'd1 : in_day;

  // day offset from january 1, feb 29 counted when year mod 4 is zero
  assign doy_calc = stlc_pkg::month_start(month_q - 4'd1) + {4'd0, day_q} - 9'd1
                  + {8'd0, (month_q > 4'd2) && (year_q[1:0] == 2'd0)};

  // festival offset from january 1
  always_comb begin
    if (cur_q[6:5] == 2'd1) begin
      fest_calc = (cur_q[4:0] != 5'd0) ? {1'b0, cur_q[4:0] - 5'd1} : 6'd0;
    end else begin
      fest_calc = {1'b0, cur_q[4:0]} + 6'd30;
    end
  end

  assign size_idx = stlc_pkg::LastSlot - slot_q;
  assign slot_ok  = (slot_q != 4'd0) && (slot_q <= stlc_pkg::LastSlot);
  assign len      = (slot_ok && sizes_q[size_idx]) ? stlc_pkg::LongMonth
                                                    : stlc_pkg::ShortMonth;

  always_comb begin
    if (lmon_q == leap_q) begin
      fwd_second = !second_q;
      fwd_lmon   = fwd_second ? lmon_q : lmon_q + 4'd1;
    end else begin
      fwd_second = second_q;
      fwd_lmon   = lmon_q + 4'd1;
    end
    bwd_lmon   = second_q ? lmon_q : lmon_q - 4'd1;
    bwd_second = (bwd_lmon == leap_q) ? !second_q : second_q;
  end

  assign status_o.after_fest = doy_q >= {3'd0, fest_q};
  assign status_o.fwd_fit    = doy_q < {4'd0, len};
  assign status_o.bwd_fit    = doy_q <= {4'd0, len};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      unique case (ctrl_i.op)
        stlc_pkg::OP_LATCH: begin
          year_q  <= in_year;
          month_q <= mon_c;
          day_q   <= day_c;
          cur_q   <= in_data_i[39:16];
          prev_q  <= in_data_i[63:47];
        end
        stlc_pkg::OP_PREP: begin
          doy_q  <= doy_calc;
          fest_q <= fest_calc;
        end
        stlc_pkg::OP_FWD_INIT: begin
          doy_q    <= doy_q - {3'd0, fest_q};
          lmon_q   <= 4'd1;
          slot_q   <= 4'd1;
          second_q <= 1'b0;
          leap_q   <= cur_q[23:20];
          sizes_q  <= cur_q[19:7];
          wrap_q   <= 1'b0;
        end
        stlc_pkg::OP_FWD_MONTH: begin
          doy_q    <= doy_q - {4'd0, len};
          slot_q   <= slot_q + 4'd1;
          lmon_q   <= fwd_lmon;
          second_q <= fwd_second;
        end
        stlc_pkg::OP_FWD_DAY: begin
          lday_q <= doy_q[4:0] + 5'd1;
        end
        stlc_pkg::OP_BWD_INIT: begin
          doy_q    <= {3'd0, fest_q} - doy_q;
          year_q   <= (year_q == 7'd0) ? stlc_pkg::LastYear : year_q - 7'd1;
          wrap_q   <= (year_q == 7'd0);
          lmon_q   <= stlc_pkg::LastMonth;
          slot_q   <= (prev_q[16:13] == 4'd0) ? stlc_pkg::LastMonth : stlc_pkg::LastSlot;
          second_q <= 1'b0;
          leap_q   <= prev_q[16:13];
          sizes_q  <= prev_q[12:0];
        end
        stlc_pkg::OP_BWD_MONTH: begin
          doy_q    <= doy_q - {4'd0, len};
          slot_q   <= slot_q - 4'd1;
          lmon_q   <= bwd_lmon;
          second_q <= bwd_second;
        end
        stlc_pkg::OP_BWD_DAY: begin
          lday_q <= len - doy_q[4:0] + 5'd1;
        end
        default: begin
        end
      endcase
    end
  end

  assign res_o.year  = year_q;
  assign res_o.month = lmon_q;
  assign res_o.day   = lday_q;
  assign res_o.wrap  = wrap_q;

endmodule

`default_nettype wire

/* src/solar_to_lunar_date_convert.sv */
// solar_to_lunar_date_convert: top level, stream ports and result register
// depends on stlc_pkg, stlc_seq and stlc_dp
//
// channel  dir  fields (tdata, lowest bit first)
// s_axis   in   solar_year[6:0] solar_month[10:7] solar_day[15:11]
//               this_year_info[39:16] prior_year_info[63:40]
// m_axis   out  lunar_year[6:0] lunar_month[10:7] lunar_day[15:11]
//               century_wrap[16] zeros[23:17]
//
// a transaction runs through the steps idle, prep, split, walk init, month walk, walk end and emit;
// the month walk in the datapath takes one lunar month per microcode step
// one date is in work at a time; s_axis_tready_o is high only while the sequencer waits
// a result sits in the output register, so the next date is taken while it waits
// reset clears the step counter and the output valid flag
`default_nettype none

module solar_to_lunar_date_convert (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire logic [stlc_pkg::InW-1:0]  s_axis_tdata_i,  // year, month, day, this info, prior info
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  output logic [stlc_pkg::OutW-1:0]      m_axis_tdata_o   // year, month, day, wrap, zero pad
);

  stlc_pkg::ctrl_t   ctrl;
  stlc_pkg::status_t status;
  stlc_pkg::res_t    res;
  stlc_pkg::res_t    res_q;
  logic              out_valid_q;
  logic              out_free;
  logic              emit;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign emit     = ctrl.exec && (ctrl.op == stlc_pkg::OP_EMIT);

  stlc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .out_free_i (out_free),
    .status_i   (status),
    .in_ready_o (s_axis_tready_o),
    .ctrl_o     (ctrl)
  );

  stlc_dp u_dp (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .in_data_i (s_axis_tdata_i),
    .status_o  (status),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, res_q};

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// tb_top: self-checking bench for solar_to_lunar_date_convert, directed table then random dates
// results are checked against typed expected values or an in-bench date converter; depends on stlc_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;

  import stlc_pkg::*;

  typedef struct {
    logic [6:0]  yr;
    logic [3:0]  mo;
    logic [4:0]  dy;
    logic [23:0] cur;
    logic [23:0] prev;
    bit          typed;
    res_t        want;
  } date_row_t;

  localparam int unsigned RandomDates = 1330;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned HoldAfter   = 400;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic [InW-1:0]      s_data = '0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic                m_ready = 1'b0;
  logic [OutW-1:0]     m_axis_tdata_o;

  res_t        expected_dates[$];
  date_row_t   date_table[$];
  int unsigned err_count = 0;
  int unsigned results_seen = 0;

  solar_to_lunar_date_convert dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned year_offset(input int unsigned mo);
    case (mo)
      1:       return 0;
      2:       return 31;
      3:       return 59;
      4:       return 90;
      5:       return 120;
      6:       return 151;
      7:       return 181;
      8:       return 212;
      9:       return 243;
      10:      return 273;
      11:      return 304;
      default: return 334;
    endcase
  endfunction

  function automatic int unsigned lunar_days(input logic [23:0] w, input int unsigned slot);
    if (slot < 1 || slot > 13) return ShortMonth;
    return w[20-slot] ? LongMonth : ShortMonth;
  endfunction

  function automatic res_t convert_date(input logic [6:0] yr_i, input logic [3:0] mo_i,
                                        input logic [4:0] dy_i, input logic [23:0] cur,
                                        input logic [23:0] prev);
    int unsigned yr, mo, dy, fday, fest, doy, back, lmon, slot, len, leap, lday;
    bit          wrap, second;
    res_t        r;
    yr = yr_i;
    mo = mo_i;
    dy = dy_i;
    wrap = 1'b0;
    second = 1'b0;
    if (mo < 1) mo = 1;
    if (mo > 12) mo = 12;
    if (dy < 1) dy = 1;
    fday = cur[4:0];
    if (cur[6:5] == 2'd1) fest = (fday > 0) ? fday - 1 : 0;
    else fest = fday + 30;
    doy = year_offset(mo) + dy - 1;
    if (mo > 2 && (yr % 4) == 0) doy = doy + 1;
    if (doy >= fest) begin
      doy = doy - fest;
      lmon = 1;
      slot = 1;
      leap = cur[23:20];
      len = lunar_days(cur, slot);
      while (doy >= len) begin
        doy = doy - len;
        slot = slot + 1;
        if (lmon == leap) begin
          second = !second;
          if (!second) lmon = lmon + 1;
        end else begin
          lmon = lmon + 1;
        end
        len = lunar_days(cur, slot);
      end
      lday = doy + 1;
    end else begin
      back = fest - doy;
      if (yr == 0) begin
        yr = LastYear;
        wrap = 1'b1;
      end else begin
        yr = yr - 1;
      end
      lmon = LastMonth;
      leap = prev[23:20];
      slot = (leap == 0) ? LastMonth : LastSlot;
      len = lunar_days(prev, slot);
      while (back > len) begin
        back = back - len;
        slot = slot - 1;
        if (!second) lmon = lmon - 1;
        if (lmon == leap) second = !second;
        len = lunar_days(prev, slot);
      end
      lday = len - back + 1;
    end
    r.year  = 7'(yr);
    r.month = 4'(lmon);
    r.day   = 5'(lday);
    r.wrap  = wrap;
    return r;
  endfunction

  function automatic logic [23:0] pack_info(input logic [3:0] leap, input logic [12:0] sizes,
                                            input logic [1:0] fmon, input logic [4:0] fday);
    return {leap, sizes, fmon, fday};
  endfunction

  function automatic logic [23:0] plausible_info();
    logic [3:0] leap;
    leap = ($urandom_range(0, 99) < 40) ? 4'($urandom_range(1, 12)) : 4'd0;
    if ($urandom_range(0, 1))
      return pack_info(leap, 13'($urandom), 2'd1, 5'($urandom_range(21, 31)));
    return pack_info(leap, 13'($urandom), 2'd2, 5'($urandom_range(1, 20)));
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_row(input logic [6:0] yr, input logic [3:0] mo, input logic [4:0] dy,
                         input logic [23:0] cur, input logic [23:0] prev,
                         input bit typed, input res_t want);
    date_row_t row;
    row.yr = yr;
    row.mo = mo;
    row.dy = dy;
    row.cur = cur;
    row.prev = prev;
    row.typed = typed;
    row.want = want;
    date_table.push_back(row);
  endtask

  task automatic send_date(input logic [6:0] yr, input logic [3:0] mo, input logic [4:0] dy,
                           input logic [23:0] cur, input logic [23:0] prev,
                           input int unsigned gap, input res_t want);
    if (gap > 0) begin
      @(negedge clk_i);
      s_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_data  <= {prev, cur, dy, mo, yr};
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_dates.push_back(want);
  endtask

  // result checker
  always @(posedge clk_i) begin
    res_t got, exp_r;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got = res_t'(m_axis_tdata_o[$bits(res_t)-1:0]);
      results_seen = results_seen + 1;
      if (expected_dates.size() == 0) begin
        if (err_count < 10) $display("unexpected transaction: %p", got);
        err_count = err_count + 1;
      end else begin
        exp_r = expected_dates.pop_front();
        if (got.year != exp_r.year || got.month != exp_r.month ||
            got.day != exp_r.day || got.wrap != exp_r.wrap) begin
          if (err_count < 10)
            $display("mismatch: expected y%0d m%0d d%0d w%0d, got y%0d m%0d d%0d w%0d",
                     exp_r.year, exp_r.month, exp_r.day, exp_r.wrap,
                     got.year, got.month, got.day, got.wrap);
          err_count = err_count + 1;
        end
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int unsigned on_len, gap;
    bit          held;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      on_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 20);
      @(negedge clk_i);
      m_ready <= 1'b1;
      repeat (on_len - 1) @(negedge clk_i);
      gap = pick_gap();
      if (!held && results_seen >= HoldAfter) begin
        held = 1'b1;
        gap = HoldCycles;
      end
      if (gap > 0) begin
        @(negedge clk_i);
        m_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  end

  initial begin
    logic [6:0]  yr;
    logic [3:0]  mo;
    logic [4:0]  dy;
    logic [23:0] cur, prev;
    res_t        want;
    int unsigned gap, mlen;

    // typed rows
    add_row(7'd5, 4'd1, 5'd1, pack_info(4'd0, 13'h0, 2'd1, 5'd1), 24'h0, 1'b1,
            '{wrap: 1'b0, day: 5'd1, month: 4'd1, year: 7'd5});
    add_row(7'd0, 4'd1, 5'd1, pack_info(4'd0, 13'h0, 2'd2, 5'd1), 24'h0, 1'b1,
            '{wrap: 1'b1, day: 5'd28, month: 4'd11, year: 7'd99});
    add_row(7'd7, 4'd1, 5'd1, pack_info(4'd0, 13'h0, 2'd1, 5'd0), 24'h0, 1'b1,
            '{wrap: 1'b0, day: 5'd1, month: 4'd1, year: 7'd7});
    add_row(7'd9, 4'd0, 5'd0, pack_info(4'd0, 13'h1fff, 2'd1, 5'd1), 24'h0, 1'b1,
            '{wrap: 1'b0, day: 5'd1, month: 4'd1, year: 7'd9});
    // predicted rows
    add_row(7'd0, 4'd2, 5'd5, pack_info(4'd0, 13'h0a5a, 2'd2, 5'd5),
            pack_info(4'd4, 13'h1b3c, 2'd2, 5'd16), 1'b0, '0);
    add_row(7'd99, 4'd12, 5'd31, 24'hffffff, 24'hffffff, 1'b0, '0);
    add_row(7'd0, 4'd12, 5'd31, pack_info(4'd0, 13'h0, 2'd1, 5'd1), 24'h0, 1'b0, '0);
    add_row(7'd0, 4'd1, 5'd1, 24'hffffff, 24'hffffff, 1'b0, '0);
    add_row(7'd0, 4'd1, 5'd1, 24'h0, 24'h0, 1'b0, '0);
    add_row(7'd12, 4'd13, 5'd31, plausible_info(), plausible_info(), 1'b0, '0);
    add_row(7'd13, 4'd15, 5'd31, plausible_info(), plausible_info(), 1'b0, '0);
    add_row(7'd20, 4'd2, 5'd10, pack_info(4'd0, 13'h155a, 2'd0, 5'd10), 24'h0, 1'b0, '0);
    add_row(7'd21, 4'd3, 5'd10, pack_info(4'd6, 13'h0f0f, 2'd3, 5'd31), 24'h0, 1'b0, '0);
    add_row(7'd100, 4'd1, 5'd2, pack_info(4'd0, 13'h0, 2'd2, 5'd3),
            pack_info(4'd12, 13'h1fff, 2'd1, 5'd25), 1'b0, '0);
    add_row(7'd127, 4'd6, 5'd15, plausible_info(), plausible_info(), 1'b0, '0);
    add_row(7'd127, 4'd1, 5'd3, pack_info(4'd0, 13'h0, 2'd2, 5'd20), 24'hffffff, 1'b0, '0);
    add_row(7'd4, 4'd2, 5'd29, plausible_info(), plausible_info(), 1'b0, '0);
    add_row(7'd4, 4'd3, 5'd1, plausible_info(), plausible_info(), 1'b0, '0);
    add_row(7'd1, 4'd3, 5'd1, plausible_info(), plausible_info(), 1'b0, '0);
    add_row(7'd33, 4'd11, 5'd20, pack_info(4'd4, 13'h0ab5, 2'd1, 5'd31), 24'h0, 1'b0, '0);
    add_row(7'd34, 4'd1, 5'd15, pack_info(4'd0, 13'h0, 2'd2, 5'd19),
            pack_info(4'd11, 13'h0d4a, 2'd2, 5'd1), 1'b0, '0);
    add_row(7'd35, 4'd1, 5'd15, pack_info(4'd0, 13'h0, 2'd2, 5'd19),
            pack_info(4'd15, 13'h0000, 2'd1, 5'd22), 1'b0, '0);
    add_row(7'd36, 4'd12, 5'd31, pack_info(4'd13, 13'h0, 2'd1, 5'd1), 24'h0, 1'b0, '0);
    add_row(7'd64, 4'd9, 5'd30, pack_info(4'd12, 13'h1555, 2'd1, 5'd31), 24'h0, 1'b0, '0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (date_table[i]) begin
      want = date_table[i].typed ? date_table[i].want :
             convert_date(date_table[i].yr, date_table[i].mo, date_table[i].dy,
                          date_table[i].cur, date_table[i].prev);
      send_date(date_table[i].yr, date_table[i].mo, date_table[i].dy,
                date_table[i].cur, date_table[i].prev, pick_gap(), want);
    end

    for (int unsigned n = 0; n < RandomDates; n++) begin
      if ($urandom_range(0, 99) < 80) begin
        yr = ($urandom_range(0, 19) == 0) ? 7'd0 : 7'($urandom_range(0, 99));
        mo = 4'($urandom_range(1, 12));
        case (mo)
          4'd2:                   mlen = (yr % 4 == 0) ? 29 : 28;
          4'd4, 4'd6, 4'd9, 4'd11: mlen = 30;
          default:                mlen = 31;
        endcase
        dy = 5'($urandom_range(1, mlen));
        cur = plausible_info();
        prev = plausible_info();
      end else begin
        yr = 7'($urandom);
        mo = 4'($urandom);
        dy = 5'($urandom);
        cur = 24'($urandom);
        prev = 24'($urandom);
      end
      gap = (n >= 500 && n < 650) ? 0 : pick_gap();
      send_date(yr, mo, dy, cur, prev, gap, convert_date(yr, mo, dy, cur, prev));
    end
    @(negedge clk_i);
    s_valid <= 1'b0;

    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_dates.size() != 0) err_count = err_count + 1;

    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* solar_to_lunar_date_convert.f */
src/stlc_pkg.sv
src/stlc_seq.sv
src/stlc_dp.sv
src/solar_to_lunar_date_convert.sv
dv/tb_top.sv
